[src/hangul_keystroke_composer_macros.svh]
// assertion helpers for the composer rtl
`ifndef HANGUL_KEYSTROKE_COMPOSER_MACROS_SVH
`define HANGUL_KEYSTROKE_COMPOSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define HKC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define HKC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hkc_pkg.sv]
// ----------------------------------------------------------------------------
// hkc_pkg
// Types, jamo tables and syllable helpers for the 2-set hangul composer.
// ----------------------------------------------------------------------------
package hkc_pkg;

    typedef enum logic [1:0] {
        EDIT_NONE = 2'd0,
        EDIT_OVR  = 2'd1,
        EDIT_INS  = 2'd2,
        EDIT_DEL  = 2'd3
    } edit_kind_t;

    typedef struct packed {
        edit_kind_t  kind;
        logic [7:0]  pos;
        logic [15:0] ch;
    } result_t;

    // composing character plus its decomposed syllable parts
    typedef struct packed {
        logic [15:0] code;
        logic        syl;
        logic [4:0]  ini;
        logic [4:0]  med;
        logic [4:0]  fin;
    } char_state_t;

    localparam logic [15:0] KEY_BACKSPACE  = 16'd8;
    localparam logic [15:0] KEY_SPACE      = 16'd32;
    localparam logic [15:0] SYL_BASE       = 16'hAC00;
    localparam logic [15:0] JAMO_FIRST     = 16'h3131;
    localparam logic [15:0] JAMO_CONS_LAST = 16'h314E;
    localparam logic [15:0] VOWEL_FIRST    = 16'h314F;
    localparam logic [15:0] JAMO_LAST      = 16'h3163;
    localparam logic [15:0] INIT_STRIDE    = 16'd588;
    localparam logic [15:0] MED_STRIDE     = 16'd28;
    localparam logic [4:0]  NO_IDX         = 5'h1F;
    localparam logic [4:0]  LAST_LETTER    = 5'd25;

    localparam logic [4:0] LT_A = 5'd0;
    localparam logic [4:0] LT_G = 5'd6;
    localparam logic [4:0] LT_J = 5'd9;
    localparam logic [4:0] LT_K = 5'd10;
    localparam logic [4:0] LT_L = 5'd11;
    localparam logic [4:0] LT_O = 5'd14;
    localparam logic [4:0] LT_P = 5'd15;
    localparam logic [4:0] LT_Q = 5'd16;
    localparam logic [4:0] LT_R = 5'd17;
    localparam logic [4:0] LT_T = 5'd19;
    localparam logic [4:0] LT_V = 5'd21;
    localparam logic [4:0] LT_W = 5'd22;
    localparam logic [4:0] LT_X = 5'd23;

    localparam logic [15:0] JAMO_PLAIN [0:25] = '{
        16'h3141, 16'h3160, 16'h314A, 16'h3147, 16'h3137, 16'h3139, 16'h314E,
        16'h3157, 16'h3151, 16'h3153, 16'h314F, 16'h3163, 16'h3161, 16'h315C,
        16'h3150, 16'h3154, 16'h3142, 16'h3131, 16'h3134, 16'h3145, 16'h3155,
        16'h314D, 16'h3148, 16'h314C, 16'h315B, 16'h314B};

    localparam logic [15:0] JAMO_SHIFT [0:25] = '{
        16'h3141, 16'h3160, 16'h314A, 16'h3147, 16'h3138, 16'h3139, 16'h314E,
        16'h3157, 16'h3151, 16'h3153, 16'h314F, 16'h3163, 16'h3161, 16'h315C,
        16'h3152, 16'h3156, 16'h3143, 16'h3132, 16'h3134, 16'h3146, 16'h3155,
        16'h314D, 16'h3149, 16'h314C, 16'h315B, 16'h314B};

    localparam logic [4:0] FINAL_PLAIN [0:25] = '{
        5'd16, 5'd0, 5'd23, 5'd21, 5'd7, 5'd8, 5'd27, 5'd0, 5'd0, 5'd0,
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd17, 5'd1, 5'd4, 5'd19,
        5'd0, 5'd26, 5'd22, 5'd25, 5'd0, 5'd24};

    localparam logic [4:0] INIT_OF_CONS [0:29] = '{
        5'd0, 5'd1, NO_IDX, 5'd2, NO_IDX, NO_IDX, 5'd3, 5'd4, 5'd5, NO_IDX,
        NO_IDX, NO_IDX, NO_IDX, NO_IDX, NO_IDX, NO_IDX, 5'd6, 5'd7, 5'd8,
        NO_IDX, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16,
        5'd17, 5'd18};

    localparam logic [15:0] CONS_OF_INIT [0:18] = '{
        16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
        16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
        16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E};

    localparam logic [4:0] INIT_OF_FINAL [0:27] = '{
        NO_IDX, 5'd0, 5'd1, 5'd9, 5'd2, 5'd12, 5'd18, 5'd3, 5'd5, 5'd0,
        5'd6, 5'd7, 5'd9, 5'd16, 5'd17, 5'd18, 5'd6, 5'd7, 5'd9, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18};

    function automatic logic [15:0] letter_jamo(input logic [4:0] l, input logic sh);
        if (l > LAST_LETTER) return 16'd0;
        return sh ? JAMO_SHIFT[l] : JAMO_PLAIN[l];
    endfunction

    function automatic logic [4:0] final_of_letter(input logic [4:0] l, input logic sh);
        if (l > LAST_LETTER) return 5'd0;
        if (!sh) return FINAL_PLAIN[l];
        if (l == LT_R) return 5'd2;
        if (l == LT_T) return 5'd20;
        return 5'd0;
    endfunction

    function automatic logic [4:0] final_split(input logic [4:0] f);
        if (f == 5'd3) return 5'd1;
        if (f == 5'd5 || f == 5'd6) return 5'd4;
        if (f >= 5'd9 && f <= 5'd15) return 5'd8;
        if (f == 5'd18) return 5'd17;
        return 5'd0;
    endfunction

    function automatic logic [4:0] final_join(input logic [4:0] f, input logic [4:0] l);
        if (l == LT_Q && f == 5'd8) return 5'd11;
        if (l == LT_W && f == 5'd4) return 5'd5;
        if (l == LT_R && f == 5'd8) return 5'd9;
        if (l == LT_T && f == 5'd1) return 5'd3;
        if (l == LT_T && f == 5'd8) return 5'd12;
        if (l == LT_T && f == 5'd17) return 5'd18;
        if (l == LT_A && f == 5'd8) return 5'd10;
        if (l == LT_G && f == 5'd4) return 5'd6;
        if (l == LT_G && f == 5'd8) return 5'd15;
        if (l == LT_X && f == 5'd8) return 5'd13;
        if (l == LT_V && f == 5'd8) return 5'd14;
        return 5'd0;
    endfunction

    function automatic logic [4:0] medial_join(input logic [4:0] m, input logic [4:0] l,
                                               input logic sh);
        if (l == LT_O && m == 5'd8 && !sh) return 5'd10;
        if (l == LT_P && m == 5'd13 && !sh) return 5'd15;
        if (l == LT_J && m == 5'd13) return 5'd14;
        if (l == LT_K && m == 5'd8) return 5'd9;
        if (l == LT_L && m == 5'd8) return 5'd11;
        if (l == LT_L && m == 5'd13) return 5'd16;
        if (l == LT_L && m == 5'd18) return 5'd19;
        return NO_IDX;
    endfunction

    function automatic logic [4:0] medial_split(input logic [4:0] m);
        if (m >= 5'd9 && m <= 5'd11) return 5'd8;
        if (m >= 5'd14 && m <= 5'd16) return 5'd13;
        if (m == 5'd19) return 5'd18;
        return NO_IDX;
    endfunction

    function automatic logic [15:0] compose(input logic [4:0] ini, input logic [4:0] med,
                                            input logic [4:0] fin);
        return SYL_BASE + 16'(ini) * INIT_STRIDE + 16'(med) * MED_STRIDE + 16'(fin);
    endfunction

    function automatic char_state_t make_syl(input logic [4:0] ini, input logic [4:0] med,
                                             input logic [4:0] fin);
        char_state_t r;
        r.code = compose(ini, med, fin);
        r.syl  = 1'b1;
        r.ini  = ini;
        r.med  = med;
        r.fin  = fin;
        return r;
    endfunction

    function automatic char_state_t make_jamo(input logic [15:0] code);
        char_state_t r;
        r.code = code;
        r.syl  = 1'b0;
        r.ini  = 5'd0;
        r.med  = 5'd0;
        r.fin  = 5'd0;
        return r;
    endfunction

endpackage

[src/hangul_keystroke_composer.sv]
// ----------------------------------------------------------------------------
// hangul_keystroke_composer
// Two-set hangul keystroke composer driving edits of an external text buffer.
// ----------------------------------------------------------------------------
// One key event (key_code, shift_held, hangul_mode) per input transfer. Each
// key yields one or two results (no edit, overwrite, insert or delete at a buffer
// position) carrying the cursor, length and composing status after the key;
// last_of_run marks the final result of a key. A key refused for a full
// buffer yields one no-edit result with overflow set.
// A transfer on in_valid/in_stall lands in an input register; once the output
// register can take the key, an edge evaluates it and loads its results there.
// The single output port drains one result a cycle while out_stall is low; a
// key with two results holds off the next key until its second result leaves.
// While out_stall is high the result holds; the input register still takes
// one more key, then in_stall rises until the output frees up.
// Reset (rst_n low, asynchronous) empties both registers and clears cursor,
// length, composing flag and composing char.
// ----------------------------------------------------------------------------
`include "hangul_keystroke_composer_macros.svh"

module hangul_keystroke_composer #(
    parameter int BUFFER_CHARS = 256,
    localparam int CNT_W = ($clog2(BUFFER_CHARS + 1) > 9) ? $clog2(BUFFER_CHARS + 1) : 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] key_code,
    input  logic        shift_held,
    input  logic        hangul_mode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  edit_kind,
    output logic [7:0]  edit_position,
    output logic [15:0] char_code,
    output logic        last_of_run,
    output logic [8:0]  cursor_now,
    output logic [8:0]  length_now,
    output logic        composing_now,
    output logic        overflow
);

    logic                 in_full_reg;
    logic [15:0]          key_reg;
    logic                 shift_reg;
    logic                 mode_reg;

    logic [CNT_W-1:0]     cursor_reg;
    logic [CNT_W-1:0]     length_reg;
    logic                 typing_reg;
    hkc_pkg::char_state_t cs_reg;

    logic                 out_valid_reg;
    hkc_pkg::result_t     out_res_reg;
    logic                 out_last_reg;
    logic                 sec_valid_reg;
    hkc_pkg::result_t     sec_res_reg;
    logic [8:0]           cursor_out_reg;
    logic [8:0]           length_out_reg;
    logic                 comp_out_reg;
    logic                 ovf_out_reg;

    logic [CNT_W-1:0]     cursor_next;
    logic [CNT_W-1:0]     length_next;
    logic                 typing_next;
    hkc_pkg::char_state_t cs_next;
    hkc_pkg::result_t     res0;
    hkc_pkg::result_t     res1;
    logic                 two_res;
    logic                 refused;

    logic                 in_xfer;
    logic                 out_xfer;
    logic                 load_ok;
    logic                 consume;

    hkc_core #(
        .BUFFER_CHARS(BUFFER_CHARS)
    ) u_core (
        .key_code   (key_reg),
        .shift_held (shift_reg),
        .hangul_mode(mode_reg),
        .cursor     (cursor_reg),
        .length     (length_reg),
        .typing     (typing_reg),
        .cs         (cs_reg),
        .cursor_next(cursor_next),
        .length_next(length_next),
        .typing_next(typing_next),
        .cs_next    (cs_next),
        .res0       (res0),
        .res1       (res1),
        .two_res    (two_res),
        .refused    (refused)
    );

    assign out_xfer = out_valid_reg && !out_stall;
    // output stage can take a new key when it is empty or its last result leaves this cycle
    assign load_ok  = !out_valid_reg || (out_xfer && !sec_valid_reg);
    assign consume  = in_full_reg && load_ok;
    assign in_stall = in_full_reg && !consume;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
        end else if (in_xfer) begin
            in_full_reg <= 1'b1;
        end else if (consume) begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            key_reg   <= key_code;
            shift_reg <= shift_held;
            mode_reg  <= hangul_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cursor_reg <= '0;
            length_reg <= '0;
            typing_reg <= 1'b0;
            cs_reg     <= hkc_pkg::make_jamo(16'd0);
        end else if (consume) begin
            cursor_reg <= cursor_next;
            length_reg <= length_next;
            typing_reg <= typing_next;
            cs_reg     <= cs_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else if (consume) begin
            out_valid_reg <= 1'b1;
            sec_valid_reg <= two_res;
        end else if (out_xfer) begin
            out_valid_reg <= sec_valid_reg;
            sec_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume) begin
            out_res_reg    <= res0;
            out_last_reg   <= !two_res;
            sec_res_reg    <= res1;
            cursor_out_reg <= cursor_next[8:0];
            length_out_reg <= length_next[8:0];
            comp_out_reg   <= typing_next;
            ovf_out_reg    <= refused;
        end else if (out_xfer && sec_valid_reg) begin
            out_res_reg  <= sec_res_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign edit_kind     = out_res_reg.kind;
    assign edit_position = out_res_reg.pos;
    assign char_code     = out_res_reg.ch;
    assign last_of_run   = out_last_reg;
    assign cursor_now    = cursor_out_reg;
    assign length_now    = length_out_reg;
    assign composing_now = comp_out_reg;
    assign overflow      = ovf_out_reg;

    `HKC_ASSERT_NOW(a_sec_needs_first, clk, rst_n, sec_valid_reg, out_valid_reg,
                    "second result without first")
    `HKC_ASSERT_NOW(a_not_last_has_sec, clk, rst_n, out_valid_reg && !out_last_reg,
                    sec_valid_reg, "open run without pending result")
    `HKC_ASSERT_NEXT(a_sec_is_last, clk, rst_n, out_xfer && sec_valid_reg,
                     out_valid_reg && out_last_reg, "second result not last")
    `HKC_ASSERT_NOW(a_len_in_range, clk, rst_n, 1'b1,
                    length_reg <= CNT_W'(BUFFER_CHARS) && cursor_reg <= length_reg,
                    "cursor or length out of range")

endmodule

[src/hkc_core.sv]
// ----------------------------------------------------------------------------
// hkc_core
// Next-state and edit logic for one key event of the composer.
// ----------------------------------------------------------------------------
module hkc_core #(
    parameter int BUFFER_CHARS = 256,
    localparam int CNT_W = ($clog2(BUFFER_CHARS + 1) > 9) ? $clog2(BUFFER_CHARS + 1) : 9
) (
    input  logic [15:0]         key_code,
    input  logic                shift_held,
    input  logic                hangul_mode,
    input  logic [CNT_W-1:0]    cursor,
    input  logic [CNT_W-1:0]    length,
    input  logic                typing,
    input  hkc_pkg::char_state_t cs,
    output logic [CNT_W-1:0]    cursor_next,
    output logic [CNT_W-1:0]    length_next,
    output logic                typing_next,
    output hkc_pkg::char_state_t cs_next,
    output hkc_pkg::result_t    res0,
    output hkc_pkg::result_t    res1,
    output logic                two_res,
    output logic                refused
);

    logic [4:0]           l;
    logic [15:0]          lj;
    logic                 vow;
    logic [4:0]           voff;
    logic                 room;
    logic                 is_letter;
    logic                 c_cons;
    logic                 c_vowel;
    logic [4:0]           cons_ini;
    logic [4:0]           msplit;
    logic [4:0]           mjoin;
    logic [4:0]           fletter;
    logic [4:0]           fjoin;
    logic [4:0]           ini2;
    logic                 do_plain;
    logic                 do_push;
    logic                 do_ovr;
    hkc_pkg::char_state_t ov_cs;
    hkc_pkg::char_state_t nw;
    logic [CNT_W-1:0]     cursor_m1;
    logic [CNT_W-1:0]     cursor_p1;
    logic [CNT_W-1:0]     plain_pos;

    always_comb
    begin
        cursor_next = cursor;
        length_next = length;
        typing_next = typing;
        cs_next     = cs;
        res0        = '{hkc_pkg::EDIT_NONE, 8'd0, 16'd0};
        res1        = '{hkc_pkg::EDIT_NONE, 8'd0, 16'd0};
        two_res     = 1'b0;
        refused     = 1'b0;
        do_plain    = 1'b0;
        do_push     = 1'b0;
        do_ovr      = 1'b0;
        ov_cs       = cs;

        l         = 5'(key_code[4:0] - 5'd1);
        lj        = hkc_pkg::letter_jamo(l, shift_held);
        vow       = (lj > hkc_pkg::JAMO_CONS_LAST);
        voff      = 5'(lj - hkc_pkg::VOWEL_FIRST);
        room      = (length < CNT_W'(BUFFER_CHARS));
        is_letter = (key_code >= 16'd65 && key_code <= 16'd90)
                 || (key_code >= 16'd97 && key_code <= 16'd122);
        c_cons    = (cs.code >= hkc_pkg::JAMO_FIRST) && (cs.code <= hkc_pkg::JAMO_CONS_LAST);
        c_vowel   = (cs.code >= hkc_pkg::VOWEL_FIRST) && (cs.code <= hkc_pkg::JAMO_LAST);
        cons_ini  = c_cons ? hkc_pkg::INIT_OF_CONS[5'(cs.code - hkc_pkg::JAMO_FIRST)]
                           : hkc_pkg::NO_IDX;
        fletter   = hkc_pkg::final_of_letter(l, shift_held);
        fjoin     = hkc_pkg::final_join(cs.fin, l);
        ini2      = (cs.fin < 5'd28) ? hkc_pkg::INIT_OF_FINAL[cs.fin] : hkc_pkg::NO_IDX;
        cursor_m1 = cursor - CNT_W'(1);
        cursor_p1 = cursor + CNT_W'(1);
        plain_pos = typing ? cursor_p1 : cursor;
        nw        = hkc_pkg::make_jamo(lj);

        // the composing char's medial, taken from a vowel jamo or a syllable
        if (cs.syl) begin
            msplit = hkc_pkg::medial_split(cs.med);
            mjoin  = hkc_pkg::medial_join(cs.med, l, shift_held);
        end else begin
            msplit = hkc_pkg::medial_split(5'(cs.code - hkc_pkg::VOWEL_FIRST));
            mjoin  = hkc_pkg::medial_join(5'(cs.code - hkc_pkg::VOWEL_FIRST), l, shift_held);
        end

        if (key_code == hkc_pkg::KEY_BACKSPACE) begin
            if (!typing) begin
                if (cursor != '0) begin
                    res0        = '{hkc_pkg::EDIT_DEL, cursor_m1[7:0], 16'd0};
                    cursor_next = cursor_m1;
                    if (length != '0) length_next = length - CNT_W'(1);
                end
            end else if (c_vowel && msplit != hkc_pkg::NO_IDX) begin
                do_ovr = 1'b1;
                ov_cs  = hkc_pkg::make_jamo(hkc_pkg::VOWEL_FIRST + 16'(msplit));
            end else if (cs.syl) begin
                do_ovr = 1'b1;
                if (cs.fin != 5'd0)
                    ov_cs = hkc_pkg::make_syl(cs.ini, cs.med, hkc_pkg::final_split(cs.fin));
                else if (msplit != hkc_pkg::NO_IDX)
                    ov_cs = hkc_pkg::make_syl(cs.ini, msplit, 5'd0);
                else
                    ov_cs = hkc_pkg::make_jamo(hkc_pkg::CONS_OF_INIT[cs.ini]);
            end else begin
                // composing jamo that cannot split further: drop it
                res0        = '{hkc_pkg::EDIT_DEL, cursor[7:0], 16'd0};
                typing_next = 1'b0;
                if (length != '0) length_next = length - CNT_W'(1);
            end
        end else if (key_code == hkc_pkg::KEY_SPACE) begin
            if (typing) begin
                cursor_next = cursor_p1;
                typing_next = 1'b0;
            end else begin
                do_plain = 1'b1;
            end
        end else if (hangul_mode && is_letter) begin
            if (!typing) begin
                if (!room) begin
                    refused = 1'b1;
                end else begin
                    cs_next     = nw;
                    res0        = '{hkc_pkg::EDIT_INS, cursor[7:0], lj};
                    length_next = length + CNT_W'(1);
                    typing_next = 1'b1;
                end
            end else if (c_cons) begin
                if (vow && cons_ini != hkc_pkg::NO_IDX) begin
                    do_ovr = 1'b1;
                    ov_cs  = hkc_pkg::make_syl(cons_ini, voff, 5'd0);
                end else begin
                    do_push = 1'b1;
                end
            end else if (c_vowel) begin
                if (mjoin != hkc_pkg::NO_IDX) begin
                    do_ovr = 1'b1;
                    ov_cs  = hkc_pkg::make_jamo(hkc_pkg::VOWEL_FIRST + 16'(mjoin));
                end else begin
                    do_push = 1'b1;
                end
            end else if (cs.syl) begin
                if (cs.fin == 5'd0 && !vow) begin
                    if (fletter != 5'd0) begin
                        do_ovr = 1'b1;
                        ov_cs  = hkc_pkg::make_syl(cs.ini, cs.med, fletter);
                    end else begin
                        do_push = 1'b1;
                    end
                end else if (cs.fin == 5'd0) begin
                    if (mjoin != hkc_pkg::NO_IDX) begin
                        do_ovr = 1'b1;
                        ov_cs  = hkc_pkg::make_syl(cs.ini, mjoin, 5'd0);
                    end else begin
                        do_push = 1'b1;
                    end
                end else if (!vow && !shift_held && fjoin != 5'd0) begin
                    do_ovr = 1'b1;
                    ov_cs  = hkc_pkg::make_syl(cs.ini, cs.med, fjoin);
                end else begin
                    do_push = 1'b1;
                end
            end else begin
                do_push = 1'b1;
            end
        end else begin
            do_plain = 1'b1;
        end

        if (do_ovr) begin
            res0    = '{hkc_pkg::EDIT_OVR, cursor[7:0], ov_cs.code};
            cs_next = ov_cs;
        end

        if (do_plain) begin
            if (!room) begin
                refused = 1'b1;
            end else begin
                res0        = '{hkc_pkg::EDIT_INS, plain_pos[7:0], key_code};
                cursor_next = plain_pos + CNT_W'(1);
                length_next = length + CNT_W'(1);
                typing_next = 1'b0;
            end
        end

        if (do_push) begin
            if (!room) begin
                refused = 1'b1;
            end else begin
                // a vowel after a final: the final, or its second part, moves on as the new initial
                if (cs.syl && vow && ini2 != hkc_pkg::NO_IDX) begin
                    res0    = '{hkc_pkg::EDIT_OVR, cursor[7:0],
                                hkc_pkg::compose(cs.ini, cs.med, hkc_pkg::final_split(cs.fin))};
                    nw      = hkc_pkg::make_syl(ini2, voff, 5'd0);
                    res1    = '{hkc_pkg::EDIT_INS, cursor_p1[7:0], nw.code};
                    two_res = 1'b1;
                end else begin
                    res0    = '{hkc_pkg::EDIT_INS, cursor_p1[7:0], nw.code};
                end
                cursor_next = cursor_p1;
                length_next = length + CNT_W'(1);
                typing_next = 1'b1;
                cs_next     = nw;
            end
        end
    end

endmodule
